// ----- sv/stbs_pkg.sv -----
`timescale 1ns / 1ps
// Package for the sorted table binary search unit: field widths, codes,
// and the command/status structs between controller and datapath. No dependencies.
package stbs_pkg;

  localparam int unsigned DEF_TABLE_DEPTH = 64;

  localparam int unsigned KEY_W    = 32;
  localparam int unsigned IDX_FW   = 6;   // entry_index / match_index field width
  localparam int unsigned CNT_FW   = 7;   // entry_count register width
  localparam int unsigned PROBE_W  = 3;

  localparam logic              MODE_WRITE  = 1'b0;
  localparam logic              MODE_SEARCH = 1'b1;
  localparam logic [CNT_FW-1:0] ENTRY_COUNT_RST = 7'd1;
  localparam logic [PROBE_W-1:0] PROBE_MAX = '1;

  // Controller -> datapath
  typedef struct packed {
    logic start;     // latch search key, open the bounds
    logic table_wr;  // store entry_key at entry_index
    logic probe;     // read entry at midpoint, count the probe
    logic step;      // compare read entry, narrow bounds or mark hit
    logic load_out;  // move the result into the output register
  } stbs_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic open;      // low bound below exclusive high bound
    logic hit;       // read entry equals the search key
    logic out_free;  // output register can take a result this cycle
  } stbs_sts_t;

endpackage

// ----- sv/stbs_cfg_if.sv -----
`timescale 1ns / 1ps
// Configuration write channel: entry_count write data with valid/ready.
// Depends on stbs_pkg.
interface stbs_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [stbs_pkg::CNT_FW-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/stbs_req_if.sv -----
`timescale 1ns / 1ps
// Input item channel: write or search request with valid/ready.
// Depends on stbs_pkg.
interface stbs_req_if;
  logic                              valid;
  logic                              ready;
  logic                              mode;
  logic        [stbs_pkg::IDX_FW-1:0] entry_index;
  logic signed [stbs_pkg::KEY_W-1:0]  entry_key;
  logic signed [stbs_pkg::KEY_W-1:0]  search_key;

  modport source (output valid, output mode, output entry_index, output entry_key,
                  output search_key, input ready);
  modport sink   (input valid, input mode, input entry_index, input entry_key,
                  input search_key, output ready);
endinterface

// ----- sv/stbs_rsp_if.sv -----
`timescale 1ns / 1ps
// Result channel: search outcome with valid/ready.
// Depends on stbs_pkg.
interface stbs_rsp_if;
  logic                               valid;
  logic                               ready;
  logic                               found;
  logic [stbs_pkg::IDX_FW-1:0]        match_index;
  logic [stbs_pkg::PROBE_W-1:0]       probe_count;

  modport source (output valid, output found, output match_index, output probe_count,
                  input ready);
  modport sink   (input valid, input found, input match_index, input probe_count,
                  output ready);
endinterface

// ----- sv/stbs_ctrl.sv -----
`timescale 1ns / 1ps
// Search sequencer for the sorted table binary search unit.
// Depends on stbs_pkg (command/status structs, mode codes).
module stbs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_mode_i,
  output logic                in_ready_o,
  input  stbs_pkg::stbs_sts_t sts_i,
  output stbs_pkg::stbs_cmd_t cmd_o
);
  import stbs_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PROBE = 2'd1;
  localparam logic [1:0] S_CMP   = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept && in_mode_i == MODE_SEARCH) begin
          cmd_o.start = 1'b1;
          state_d     = S_PROBE;
        end else if (accept) begin
          cmd_o.table_wr = 1'b1;
        end
      end
      S_PROBE: begin
        if (sts_i.open) begin
          cmd_o.probe = 1'b1;
          state_d     = S_CMP;
        end else begin
          state_d = S_FIN;
        end
      end
      S_CMP: begin
        cmd_o.step = 1'b1;
        state_d    = sts_i.hit ? S_FIN : S_PROBE;
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- sv/stbs_dp.sv -----
`timescale 1ns / 1ps
// Datapath: key table memory, search bounds, probe counter, config register
// and result register. Depends on stbs_pkg and the channel interfaces.
module stbs_dp #(
  parameter int unsigned TABLE_DEPTH = stbs_pkg::DEF_TABLE_DEPTH
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  stbs_cfg_if.sink                             cfg_i,
  input  logic [stbs_pkg::IDX_FW-1:0]          entry_index_i,
  input  logic signed [stbs_pkg::KEY_W-1:0]    entry_key_i,
  input  logic signed [stbs_pkg::KEY_W-1:0]    search_key_i,
  stbs_rsp_if.source                           rsp_o,
  input  stbs_pkg::stbs_cmd_t                  cmd_i,
  output stbs_pkg::stbs_sts_t                  sts_o
);
  import stbs_pkg::*;

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned BND_W = IDX_W + 1;
  localparam int unsigned CMP_W = (BND_W > CNT_FW) ? BND_W : CNT_FW;

  logic signed [KEY_W-1:0] mem [TABLE_DEPTH];
  logic signed [KEY_W-1:0] rdata_q;

  logic [CNT_FW-1:0]       entry_count_q;
  logic signed [KEY_W-1:0] key_q;
  logic [BND_W-1:0]        lo_q, hp_q;   // search range is [lo, hp)
  logic [IDX_W-1:0]        mid_q;
  logic [PROBE_W-1:0]      probes_q;
  logic                    hit_q;

  logic                    out_valid_q;
  logic                    out_found_q;
  logic [IDX_FW-1:0]       out_index_q;
  logic [PROBE_W-1:0]      out_probes_q;

  logic [CMP_W-1:0]        count_ext;
  logic [CMP_W-1:0]        n_clamped;
  logic [BND_W:0]          mid_sum;
  logic [IDX_W-1:0]        mid;
  logic                    wr_in_range;

  // Active entries, saturated to the table depth
  assign count_ext = CMP_W'(entry_count_q);
  assign n_clamped = (count_ext > CMP_W'(TABLE_DEPTH)) ? CMP_W'(TABLE_DEPTH) : count_ext;

  // floor((lo + hi) / 2) with hi = hp - 1; lo < hp keeps it non-negative
  assign mid_sum = {1'b0, lo_q} + {1'b0, hp_q} - (BND_W+1)'(1);
  assign mid     = mid_sum[IDX_W:1];

  assign wr_in_range = CMP_W'(entry_index_i) < CMP_W'(TABLE_DEPTH);

  assign sts_o.open     = lo_q < hp_q;
  assign sts_o.hit      = rdata_q == key_q;
  assign sts_o.out_free = !out_valid_q || rsp_o.ready;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= ENTRY_COUNT_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      entry_count_q <= cfg_i.data;
    end
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.table_wr && wr_in_range) begin
      mem[IDX_W'(entry_index_i)] <= entry_key_i;
    end
    if (cmd_i.probe) begin
      rdata_q <= mem[mid];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q     <= '0;
      hp_q     <= '0;
      probes_q <= '0;
      hit_q    <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        lo_q     <= '0;
        hp_q     <= BND_W'(n_clamped);
        probes_q <= '0;
        hit_q    <= 1'b0;
      end
      if (cmd_i.probe && probes_q != PROBE_MAX) begin
        probes_q <= probes_q + PROBE_W'(1);
      end
      if (cmd_i.step) begin
        if (rdata_q == key_q) begin
          hit_q <= 1'b1;
        end else if (rdata_q < key_q) begin
          lo_q <= BND_W'(mid_q) + BND_W'(1);
        end else begin
          hp_q <= BND_W'(mid_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      key_q <= search_key_i;
    end
    if (cmd_i.probe) begin
      mid_q <= mid;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_found_q  <= hit_q;
      out_index_q  <= hit_q ? IDX_FW'(mid_q) : '0;
      out_probes_q <= probes_q;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.found       = out_found_q;
  assign rsp_o.match_index = out_index_q;
  assign rsp_o.probe_count = out_probes_q;

  // A probe is only issued on a non-empty range
  a_probe_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.probe |-> lo_q < hp_q)
    else $error("probe issued with empty search range");

  // Bounds never cross past each other
  a_bounds_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lo_q <= hp_q)
    else $error("search bounds crossed");

  // A pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || rsp_o.ready))
    else $error("result register overwritten while stalled");

  // A compare step always follows a probe read
  a_step_after_probe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> $past(cmd_i.probe))
    else $error("compare without a preceding table read");

endmodule

// ----- sv/sorted_table_binary_search_unit.sv -----
`timescale 1ns / 1ps
// Sorted table binary search unit.
// Usage:
//  - req_i carries items. mode write stores entry_key at entry_index (no result;
//    indexes at or above TABLE_DEPTH are dropped). mode search looks up
//    search_key by binary search over entries 0 .. entry_count-1.
//  - rsp_o returns one result per search: found, match_index (0 on a miss) and
//    probe_count (saturates at 7).
//  - cfg_i writes entry_count; always ready; write it only while idle. Counts
//    above TABLE_DEPTH saturate; zero gives a miss with no probes.
// Timing: after a write transfer the next item may follow at once.
//  A search runs probe by probe (registered table read, then compare and bound
//  update), P probes in all, with P <= 7 for a 64-entry table. req_i.ready
//  stays low until the result is loaded, so a search holds the input.
// Stalls: a finished result waits in the output register. Writes and the next
//  search still run; that search holds in its last step until rsp_o.ready frees
//  the register, and req_i.ready stays low meanwhile.
// Reset: rst_ni clears control and sets entry_count to 1. Table contents are
//  undefined until written; search only written entries. Needs stbs_pkg,
//  the channel interfaces, stbs_ctrl and stbs_dp.
module sorted_table_binary_search_unit #(
  parameter int unsigned TABLE_DEPTH = stbs_pkg::DEF_TABLE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  stbs_cfg_if.sink    cfg_i,
  stbs_req_if.sink    req_i,
  stbs_rsp_if.source  rsp_o
);
  import stbs_pkg::*;

  stbs_cmd_t cmd;
  stbs_sts_t sts;
  logic      in_ready;

  assign req_i.ready = in_ready;

  // Sequencer: accepts items, steps the search one probe at a time
  stbs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_mode_i  (req_i.mode),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Table, bounds, counter and result register
  stbs_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_i),
    .entry_index_i (req_i.entry_index),
    .entry_key_i   (req_i.entry_key),
    .search_key_i  (req_i.search_key),
    .rsp_o         (rsp_o),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule
